/* design/wbps_pkg.sv */
// Package for the wildcard byte pattern scanner.
// Holds shared widths, command and register codes and the window control type.
// No dependencies.
package wbps_pkg;

  // Default pattern capacity in bytes.
  localparam int MAX_PATTERN_DEF = 64;

  // Fixed field widths.
  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 6;
  localparam int LEN_W    = 7;
  localparam int CNT_W    = 32;
  localparam int ADDR_W   = 64;

  // Configuration port widths.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 64;

  // Word commands.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SCAN = 1'b1;

  // Register select, taken from bit 3 of the byte address.
  localparam logic REG_PATTERN_LENGTH = 1'b0;
  localparam logic REG_REGION_BASE    = 1'b1;

  // Control of the byte window for one processed word.
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

endpackage

/* design/wildcard_byte_pattern_scanner.sv */
// Top level of the wildcard byte pattern scanner.
// Instantiates wbps_cfg, wbps_pattern_store and wbps_window; uses wbps_pkg.
//
// Usage:
// Words enter on the in_ channel (valid/stall). A load word (command 0)
// writes one pattern byte and its wildcard flag; a scan word (command 1)
// pushes one region byte into the window, which is compared against the
// first pattern_length pattern bytes at once. The first match in a region
// gives one out_ word with out_found high and the address region_base plus
// the match start offset. A region whose last byte passes without a match
// gives one word with out_found low and address zero.
// A word passes the input register, then the compare and address add into
// the result register that drives out_valid.
// Throughput is one word per cycle unless a stalled result holds the flow.
// A pending result may wait on out_stall while one more word is taken into
// the input register; input stalls only while a result is held and stalled.
// Reset empties the window, clears the byte count and both registers; the
// pattern store is not cleared and must be loaded before use.
// Configuration is written through the cfg_ port at byte addresses 0 and 8.
module wildcard_byte_pattern_scanner #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_command,
  input  logic [wbps_pkg::IDX_W-1:0]         in_entry_index,
  input  logic [wbps_pkg::BYTE_W-1:0]        in_data_byte,
  input  logic                               in_is_wildcard,
  input  logic                               in_last_byte,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_found,
  output logic [wbps_pkg::ADDR_W-1:0]        out_match_address,
  // Configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [wbps_pkg::APB_ADDR_W-1:0]    cfg_paddr,
  input  logic [wbps_pkg::APB_DATA_W-1:0]    cfg_pwdata,
  output logic [wbps_pkg::APB_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  localparam int POS_W = $clog2(MAX_PATTERN + 1);
  localparam int CMP_W = (POS_W > wbps_pkg::LEN_W) ? POS_W : wbps_pkg::LEN_W;

  // Configuration
  logic [wbps_pkg::LEN_W-1:0]  pattern_length_r;
  logic [wbps_pkg::ADDR_W-1:0] region_base_r;

  // Input register
  logic                        in_valid_r;
  logic                        cmd_r;
  logic [wbps_pkg::IDX_W-1:0]  index_r;
  logic [wbps_pkg::BYTE_W-1:0] byte_r;
  logic                        wild_r;
  logic                        last_r;

  // Region state
  logic [wbps_pkg::CNT_W-1:0]  bytes_seen_r, bytes_seen_nxt;
  logic                        reported_r, reported_nxt;

  // Result register
  logic                        out_valid_r;
  logic                        found_r;
  logic [wbps_pkg::ADDR_W-1:0] addr_r;

  // Processing signals
  logic                                         advance;
  logic                                         in_take;
  logic                                         scan_fire;
  logic                                         load_fire;
  logic                                         win_match;
  logic                                         len_ok;
  logic                                         seen_ok;
  logic                                         hit;
  logic                                         res_valid;
  logic [wbps_pkg::CNT_W-1:0]                   bytes_inc;
  logic [wbps_pkg::CNT_W-1:0]                   offset;
  logic [wbps_pkg::ADDR_W-1:0]                  hit_addr;
  wbps_pkg::win_ctl_t                           win_ctl;
  logic [MAX_PATTERN-1:0][wbps_pkg::BYTE_W-1:0] pat_bytes;
  logic [MAX_PATTERN-1:0]                       pat_wild;

  wbps_cfg u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (cfg_psel),
    .penable          (cfg_penable),
    .pwrite           (cfg_pwrite),
    .paddr            (cfg_paddr),
    .pwdata           (cfg_pwdata),
    .prdata           (cfg_prdata),
    .pready           (cfg_pready),
    .pattern_length_r (pattern_length_r),
    .region_base_r    (region_base_r)
  );

  // The processing stage moves whenever the result register can take a word.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign scan_fire = in_valid_r && advance && (cmd_r == wbps_pkg::CMD_SCAN);
  assign load_fire = in_valid_r && advance && (cmd_r == wbps_pkg::CMD_LOAD);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r   <= in_command;
      index_r <= in_entry_index;
      byte_r  <= in_data_byte;
      wild_r  <= in_is_wildcard;
      last_r  <= in_last_byte;
    end
  end

  wbps_pattern_store #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_store (
    .clk       (clk),
    .wr_en     (load_fire),
    .wr_index  (index_r),
    .wr_byte   (byte_r),
    .wr_wild   (wild_r),
    .pat_bytes (pat_bytes),
    .pat_wild  (pat_wild)
  );

  assign win_ctl.shift = scan_fire;
  assign win_ctl.clear = last_r;

  wbps_window #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (win_ctl),
    .data_byte (byte_r),
    .len       (pattern_length_r),
    .pat_bytes (pat_bytes),
    .pat_wild  (pat_wild),
    .win_match (win_match)
  );

  // Match decision for the current scan word.
  assign bytes_inc = (bytes_seen_r == '1) ? bytes_seen_r : bytes_seen_r + 1'b1;
  assign len_ok    = (pattern_length_r != '0) &&
                     (CMP_W'(pattern_length_r) <= CMP_W'(MAX_PATTERN));
  assign seen_ok   = bytes_inc >= wbps_pkg::CNT_W'(pattern_length_r);
  assign hit       = !reported_r && (region_base_r != '0) && len_ok && seen_ok &&
                     win_match;
  assign offset    = bytes_inc - wbps_pkg::CNT_W'(pattern_length_r);
  assign hit_addr  = region_base_r + wbps_pkg::ADDR_W'(offset);
  assign res_valid = scan_fire && (hit || (last_r && !reported_r));

  // Region state: cleared at the last byte, otherwise counted and latched.
  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    reported_nxt   = reported_r;
    if (scan_fire) begin
      if (last_r) begin
        bytes_seen_nxt = '0;
        reported_nxt   = 1'b0;
      end else begin
        bytes_seen_nxt = bytes_inc;
        reported_nxt   = reported_r | hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      reported_r   <= 1'b0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      reported_r   <= reported_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      found_r <= hit;
      addr_r  <= hit ? hit_addr : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = found_r;
  assign out_match_address = addr_r;

endmodule

/* design/wbps_cfg.sv */
// Configuration registers of the wildcard byte pattern scanner (APB-style port).
// Holds the pattern length and the region base address.
// Depends on wbps_pkg.
module wbps_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wbps_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [wbps_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [wbps_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [wbps_pkg::LEN_W-1:0]       pattern_length_r,
  output logic [wbps_pkg::ADDR_W-1:0]      region_base_r
);

  logic wr_en;

  // The port never inserts wait states.
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes; the register is selected by address bit 3.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= '0;
      region_base_r    <= '0;
    end else if (wr_en) begin
      case (paddr[3])
        wbps_pkg::REG_PATTERN_LENGTH: pattern_length_r <= pwdata[wbps_pkg::LEN_W-1:0];
        wbps_pkg::REG_REGION_BASE:    region_base_r    <= pwdata;
        default: ;
      endcase
    end
  end

  // Read-back.
  always_comb begin
    case (paddr[3])
      wbps_pkg::REG_PATTERN_LENGTH:
        prdata = wbps_pkg::APB_DATA_W'(pattern_length_r);
      wbps_pkg::REG_REGION_BASE:
        prdata = region_base_r;
      default:
        prdata = '0;
    endcase
  end

endmodule

/* design/wbps_pattern_store.sv */
// Pattern store of the wildcard byte pattern scanner: one byte and one
// wildcard flag per pattern position, all visible in parallel.
// Depends on wbps_pkg.
module wbps_pattern_store #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [wbps_pkg::IDX_W-1:0]                   wr_index,
  input  logic [wbps_pkg::BYTE_W-1:0]                  wr_byte,
  input  logic                                         wr_wild,
  output logic [MAX_PATTERN-1:0][wbps_pkg::BYTE_W-1:0] pat_bytes,
  output logic [MAX_PATTERN-1:0]                       pat_wild
);

  localparam int POS_W = $clog2(MAX_PATTERN + 1);
  localparam int CMP_W = (POS_W > wbps_pkg::IDX_W) ? POS_W : wbps_pkg::IDX_W;

  logic [MAX_PATTERN-1:0][wbps_pkg::BYTE_W-1:0] bytes_r;
  logic [MAX_PATTERN-1:0]                       wild_r;

  // Each entry decodes its own write; an index beyond the store hits nothing.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_entry
    always_ff @(posedge clk) begin
      if (wr_en && (CMP_W'(wr_index) == CMP_W'(k))) begin
        bytes_r[k] <= wr_byte;
        wild_r[k]  <= wr_wild;
      end
    end
  end

  assign pat_bytes = bytes_r;
  assign pat_wild  = wild_r;

endmodule

/* design/wbps_window.sv */
// Byte window of the wildcard byte pattern scanner and its parallel compare.
// The newest byte enters at the top; the window is aligned to the pattern by
// a barrel shift and compared position by position.
// Depends on wbps_pkg.
module wbps_window #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  wbps_pkg::win_ctl_t                           ctl,
  input  logic [wbps_pkg::BYTE_W-1:0]                  data_byte,
  input  logic [wbps_pkg::LEN_W-1:0]                   len,
  input  logic [MAX_PATTERN-1:0][wbps_pkg::BYTE_W-1:0] pat_bytes,
  input  logic [MAX_PATTERN-1:0]                       pat_wild,
  output logic                                         win_match
);

  localparam int SH_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int POS_W = $clog2(MAX_PATTERN + 1);
  localparam int CMP_W = (POS_W > wbps_pkg::LEN_W) ? POS_W : wbps_pkg::LEN_W;

  logic [MAX_PATTERN-1:0][wbps_pkg::BYTE_W-1:0] win_r, win_nxt, shifted;
  logic [MAX_PATTERN-1:0][wbps_pkg::BYTE_W-1:0] lvl [SH_W+1];
  logic [CMP_W-1:0]                             gap;
  logic [SH_W-1:0]                              sh_amt;
  logic [MAX_PATTERN-1:0]                       pos_ok;

  // Window after taking the new byte: entry 0 is the oldest byte.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_shift
    if (k == MAX_PATTERN - 1) begin : g_top
      assign shifted[k] = data_byte;
    end else begin : g_mid
      assign shifted[k] = win_r[k+1];
    end
  end

  // The pattern covers the newest len bytes, starting at MAX_PATTERN - len.
  assign gap    = CMP_W'(MAX_PATTERN) - CMP_W'(len);
  assign sh_amt = gap[SH_W-1:0];

  // Barrel shift towards entry 0 so that pattern position j meets window
  // entry j + gap.
  assign lvl[0] = shifted;
  for (genvar s = 0; s < SH_W; s++) begin : g_lvl
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pos
      if (j + (1 << s) < MAX_PATTERN) begin : g_in
        assign lvl[s+1][j] = sh_amt[s] ? lvl[s][j + (1 << s)] : lvl[s][j];
      end else begin : g_out
        assign lvl[s+1][j] = sh_amt[s] ? '0 : lvl[s][j];
      end
    end
  end

  // Positions beyond the pattern length, and wildcards, always agree.
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cmp
    assign pos_ok[j] = (CMP_W'(j) >= CMP_W'(len)) | pat_wild[j] |
                       (lvl[SH_W][j] == pat_bytes[j]);
  end

  assign win_match = &pos_ok;

  // Window register: shifts on every scan word and empties at region end.
  assign win_nxt = ctl.clear ? '0 : shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (ctl.shift) begin
      win_r <= win_nxt;
    end
  end

endmodule

/* design/wbps_checker.sv */
// Port-level checker for the wildcard byte pattern scanner, bound to the
// top level. Depends on wbps_pkg and wildcard_byte_pattern_scanner.
module wbps_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               out_found,
  input logic [wbps_pkg::ADDR_W-1:0]        out_match_address
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_found) && $stable(out_match_address))
    else $error("result payload changed while stalled");

  // A not-found report always carries address zero.
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_address == '0)
    else $error("not-found word with non-zero address");

  // Input is held back only by a stalled, waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Reset leaves no result on offer.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_checker (.*);
